[src/hsvsa_pkg.sv]
// Shared types, constants and hue decode helpers for the HSV to RGB add unit.
`timescale 1ns / 1ps
package hsvsa_pkg;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5,
    SECTOR_6 = 3'd6
  } sector_e;

  localparam logic [13:0] FULL_TERM   = 14'd10710;
  localparam logic [5:0]  FRAC_MAX    = 6'd42;
  localparam logic [7:0]  CHAN_MAX    = 8'd255;
  // floor(x / 42) == (x * 24967) >> 20 for every x up to 10710
  localparam logic [14:0] DIV42_RECIP = 15'd24967;
  localparam int          DIV42_SHIFT = 20;

  typedef struct packed {
    sector_e    sector;
    logic       gray;
    logic [7:0] v;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } terms_t;

  // Sector boundaries are where hue * 16 crosses multiples of 680.
  function automatic sector_e hue_sector(input logic [7:0] hue);
    sector_e sec;
    priority if (hue >= 8'd255) begin
      sec = SECTOR_6;
    end else if (hue >= 8'd213) begin
      sec = SECTOR_5;
    end else if (hue >= 8'd170) begin
      sec = SECTOR_4;
    end else if (hue >= 8'd128) begin
      sec = SECTOR_3;
    end else if (hue >= 8'd85) begin
      sec = SECTOR_2;
    end else if (hue >= 8'd43) begin
      sec = SECTOR_1;
    end else begin
      sec = SECTOR_0;
    end
    return sec;
  endfunction

  function automatic logic [5:0] hue_frac(input logic [7:0] hue, input sector_e sec);
    logic [11:0] h16;
    logic [11:0] base;
    logic [11:0] diff;
    h16 = {hue, 4'b0000};
    unique case (sec)
      SECTOR_1: base = 12'd680;
      SECTOR_2: base = 12'd1360;
      SECTOR_3: base = 12'd2040;
      SECTOR_4: base = 12'd2720;
      SECTOR_5: base = 12'd3400;
      SECTOR_6: base = 12'd4080;
      default:  base = 12'd0;
    endcase
    diff = h16 - base;
    return diff[9:4];
  endfunction

endpackage

[src/hsv_to_rgb_saturating_add_unit.sv]
// Top level: six-stage pipelined HSV to RGB conversion with saturating accumulate.
// Each accepted input beat is registered through stages 1 to 6 before its result reaches the output.
// Throughput: one beat per cycle; each stage holds when the next one is full and stalled,
//   and empty stages fill while the output waits.
// The divide by 42 is a reciprocal multiply in its own stage; each multiplier is registered.
// Reset clears the stage valid bits only; payload registers are not reset.
`timescale 1ns / 1ps
module hsv_to_rgb_saturating_add_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [9:0] pixel_index_i,
  input  logic [7:0] hue_i,
  input  logic [7:0] saturation_i,
  input  logic [7:0] brightness_i,
  input  logic [7:0] current_red_i,
  input  logic [7:0] current_green_i,
  input  logic [7:0] current_blue_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [9:0] out_index_o,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o
);
  import hsvsa_pkg::*;

  typedef struct packed {
    logic [9:0] idx;
    logic [7:0] cr;
    logic [7:0] cg;
    logic [7:0] cb;
    logic [7:0] v;
  } pass_t;

  localparam int NUM_STAGES = 6;

  logic [NUM_STAGES:1] valid_q;
  logic [NUM_STAGES:1] ready;

  // Stage 1: hue decode
  pass_t      s1_pass_q;
  logic [7:0] s1_sat_q;
  sector_e    s1_sector_q;
  logic [5:0] s1_frac_q;
  logic       s1_gray_q;
  sector_e    s1_sector_d;

  // Stage 2: products with saturation
  pass_t       s2_pass_q;
  sector_e     s2_sector_q;
  logic        s2_gray_q;
  logic [7:0]  s2_p_q;
  logic [13:0] s2_mq_q;
  logic [13:0] s2_mt_q;
  logic [13:0] s2_mq_d;
  logic [13:0] s2_mt_d;
  logic [15:0] s2_pprod;
  logic [5:0]  s2_frac_inv;

  // Stage 3: numerators
  pass_t       s3_pass_q;
  sector_e     s3_sector_q;
  logic        s3_gray_q;
  logic [7:0]  s3_p_q;
  logic [13:0] s3_xq_q;
  logic [13:0] s3_xt_q;

  // Stage 4: divide by 42
  pass_t       s4_pass_q;
  sector_e     s4_sector_q;
  logic        s4_gray_q;
  logic [7:0]  s4_p_q;
  logic [7:0]  s4_dq_q;
  logic [7:0]  s4_dt_q;
  logic [28:0] s4_qprod;
  logic [28:0] s4_tprod;

  // Stage 5: scale by brightness
  pass_t       s5_pass_q;
  terms_t      s5_terms_q;
  logic [15:0] s5_qprod;
  logic [15:0] s5_tprod;

  // Stage 6: output
  logic [9:0] s6_idx_q;
  logic [7:0] s6_red_q;
  logic [7:0] s6_green_q;
  logic [7:0] s6_blue_q;
  logic [7:0] s6_red_d;
  logic [7:0] s6_green_d;
  logic [7:0] s6_blue_d;

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    ready[NUM_STAGES] = !valid_q[NUM_STAGES] || !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      ready[k] = !valid_q[k] || ready[k + 1];
    end
  end

  assign in_stall_o = !ready[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[1]) valid_q[1] <= in_valid_i;
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (ready[k]) valid_q[k] <= valid_q[k - 1];
      end
    end
  end

  assign s1_sector_d = hue_sector(hue_i);

  always_ff @(posedge clk_i) begin
    if (ready[1]) begin
      s1_pass_q   <= '{idx: pixel_index_i, cr: current_red_i, cg: current_green_i,
                       cb: current_blue_i, v: brightness_i};
      s1_sat_q    <= saturation_i;
      s1_sector_q <= s1_sector_d;
      s1_frac_q   <= hue_frac(hue_i, s1_sector_d);
      s1_gray_q   <= (saturation_i == 8'd0);
    end
  end

  assign s2_frac_inv = FRAC_MAX - s1_frac_q;
  assign s2_mq_d     = {6'd0, s1_sat_q} * {8'd0, s1_frac_q};
  assign s2_mt_d     = {6'd0, s1_sat_q} * {8'd0, s2_frac_inv};
  assign s2_pprod    = {8'd0, s1_pass_q.v} * {8'd0, CHAN_MAX - s1_sat_q};

  always_ff @(posedge clk_i) begin
    if (ready[2]) begin
      s2_pass_q   <= s1_pass_q;
      s2_sector_q <= s1_sector_q;
      s2_gray_q   <= s1_gray_q;
      s2_p_q      <= s2_pprod[15:8];
      s2_mq_q     <= s2_mq_d;
      s2_mt_q     <= s2_mt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[3]) begin
      s3_pass_q   <= s2_pass_q;
      s3_sector_q <= s2_sector_q;
      s3_gray_q   <= s2_gray_q;
      s3_p_q      <= s2_p_q;
      s3_xq_q     <= FULL_TERM - s2_mq_q;
      s3_xt_q     <= FULL_TERM - s2_mt_q;
    end
  end

  assign s4_qprod = {15'd0, s3_xq_q} * {14'd0, DIV42_RECIP};
  assign s4_tprod = {15'd0, s3_xt_q} * {14'd0, DIV42_RECIP};

  always_ff @(posedge clk_i) begin
    if (ready[4]) begin
      s4_pass_q   <= s3_pass_q;
      s4_sector_q <= s3_sector_q;
      s4_gray_q   <= s3_gray_q;
      s4_p_q      <= s3_p_q;
      s4_dq_q     <= s4_qprod[DIV42_SHIFT +: 8];
      s4_dt_q     <= s4_tprod[DIV42_SHIFT +: 8];
    end
  end

  assign s5_qprod = {8'd0, s4_pass_q.v} * {8'd0, s4_dq_q};
  assign s5_tprod = {8'd0, s4_pass_q.v} * {8'd0, s4_dt_q};

  always_ff @(posedge clk_i) begin
    if (ready[5]) begin
      s5_pass_q  <= s4_pass_q;
      s5_terms_q <= '{sector: s4_sector_q, gray: s4_gray_q, v: s4_pass_q.v,
                      p: s4_p_q, q: s5_qprod[15:8], t: s5_tprod[15:8]};
    end
  end

  hsvsa_chan_sel u_chan_sel (
    .terms_i     (s5_terms_q),
    .cur_red_i   (s5_pass_q.cr),
    .cur_green_i (s5_pass_q.cg),
    .cur_blue_i  (s5_pass_q.cb),
    .red_o       (s6_red_d),
    .green_o     (s6_green_d),
    .blue_o      (s6_blue_d)
  );

  always_ff @(posedge clk_i) begin
    if (ready[6]) begin
      s6_idx_q   <= s5_pass_q.idx;
      s6_red_q   <= s6_red_d;
      s6_green_q <= s6_green_d;
      s6_blue_q  <= s6_blue_d;
    end
  end

  assign out_valid_o = valid_q[NUM_STAGES];
  assign out_index_o = s6_idx_q;
  assign out_red_o   = s6_red_q;
  assign out_green_o = s6_green_q;
  assign out_blue_o  = s6_blue_q;

endmodule

[src/hsvsa_chan_sel.sv]
// Channel routing by hue sector and saturating add onto the current pixel color.
`timescale 1ns / 1ps
module hsvsa_chan_sel (
  input  hsvsa_pkg::terms_t terms_i,
  input  logic [7:0]        cur_red_i,
  input  logic [7:0]        cur_green_i,
  input  logic [7:0]        cur_blue_i,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o
);
  import hsvsa_pkg::*;

  logic [7:0] conv_r;
  logic [7:0] conv_g;
  logic [7:0] conv_b;

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[8] ? CHAN_MAX : sum[7:0];
  endfunction

  always_comb begin
    if (terms_i.gray) begin
      conv_r = terms_i.v;
      conv_g = terms_i.v;
      conv_b = terms_i.v;
    end else begin
      unique case (terms_i.sector)
        SECTOR_1: begin
          conv_r = terms_i.q; conv_g = terms_i.v; conv_b = terms_i.p;
        end
        SECTOR_2: begin
          conv_r = terms_i.p; conv_g = terms_i.v; conv_b = terms_i.t;
        end
        SECTOR_3: begin
          conv_r = terms_i.p; conv_g = terms_i.q; conv_b = terms_i.v;
        end
        SECTOR_4: begin
          conv_r = terms_i.t; conv_g = terms_i.p; conv_b = terms_i.v;
        end
        SECTOR_5: begin
          conv_r = terms_i.v; conv_g = terms_i.p; conv_b = terms_i.q;
        end
        // first and top sector share one mapping
        default: begin
          conv_r = terms_i.v; conv_g = terms_i.t; conv_b = terms_i.p;
        end
      endcase
    end
  end

  assign red_o   = sat_add(cur_red_i, conv_r);
  assign green_o = sat_add(cur_green_i, conv_g);
  assign blue_o  = sat_add(cur_blue_i, conv_b);

endmodule
